// ===== sv/rce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rce_pkg;

    // frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // field and register widths
    localparam int PIX_W  = 8;
    localparam int TAG_W  = 10;
    localparam int CFG_W  = 11;
    localparam int ADDR_W = $clog2(MAX_WIDTH);

    localparam logic [CFG_W-1:0] MAX_W_DIM = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MAX_H_DIM = CFG_W'(MAX_HEIGHT);

    // configuration register indexes
    localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

    // pixel held in the window stage with its position
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] left;
        logic [TAG_W-1:0] row;
        logic [TAG_W-1:0] col;
        logic             row_end;
        logic             last_row;
    } rce_item_t;

endpackage

`default_nettype wire

// ===== sv/rce_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read-first: a read and write to the same address return the old word
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/rce_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rce_scan (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [0:0]                       cfg_index,
    input  wire logic [rce_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                             pix_valid,
    output logic                                  pix_ready,
    input  wire logic [rce_pkg::PIX_W-1:0]        pixel,
    input  wire logic                             item_done,
    output logic                                  item_valid,
    output rce_pkg::rce_item_t                    item,
    output logic                                  ram_wr_en,
    output logic      [rce_pkg::ADDR_W-1:0]       ram_addr,
    output logic      [rce_pkg::PIX_W-1:0]        ram_wr_data
);

    logic [rce_pkg::CFG_W-1:0] width_reg;
    logic [rce_pkg::CFG_W-1:0] height_reg;
    logic [rce_pkg::TAG_W-1:0] col_reg;
    logic [rce_pkg::TAG_W-1:0] col_next;
    logic [rce_pkg::TAG_W-1:0] row_reg;
    logic [rce_pkg::TAG_W-1:0] row_next;
    logic [rce_pkg::PIX_W-1:0] left_reg;
    logic                      valid_reg;
    logic                      valid_next;
    rce_pkg::rce_item_t        item_reg;
    rce_pkg::rce_item_t        item_next;
    logic [rce_pkg::CFG_W-1:0] eff_w;
    logic [rce_pkg::CFG_W-1:0] eff_h;
    logic                      row_end;
    logic                      last_row;
    logic                      accept;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rce_pkg::MAX_W_DIM;
            height_reg <= rce_pkg::MAX_H_DIM;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rce_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                rce_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size, zero acts as one, values above the maximum clamp to it
    always_comb
    begin
        if (width_reg == '0)
            eff_w = rce_pkg::CFG_W'(1);
        else if (width_reg > rce_pkg::MAX_W_DIM)
            eff_w = rce_pkg::MAX_W_DIM;
        else
            eff_w = width_reg;

        if (height_reg == '0)
            eff_h = rce_pkg::CFG_W'(1);
        else if (height_reg > rce_pkg::MAX_H_DIM)
            eff_h = rce_pkg::MAX_H_DIM;
        else
            eff_h = height_reg;
    end

    assign row_end  = ({1'b0, col_reg} + rce_pkg::CFG_W'(1)) >= eff_w;
    assign last_row = ({1'b0, row_reg} + rce_pkg::CFG_W'(1)) >= eff_h;

    // stage is free when empty or when its item finishes this cycle
    assign pix_ready = !valid_reg || item_done;
    assign accept    = pix_valid && pix_ready;

    // raster position and stage load
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        valid_next = valid_reg;
        item_next  = item_reg;
        if (item_done)
            valid_next = 1'b0;
        if (accept)
        begin
            valid_next         = 1'b1;
            item_next.pixel    = pixel;
            item_next.left     = left_reg;
            item_next.row      = row_reg;
            item_next.col      = col_reg;
            item_next.row_end  = row_end;
            item_next.last_row = last_row;
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + rce_pkg::TAG_W'(1);
            end
            else
            begin
                col_next = col_reg + rce_pkg::TAG_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            left_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
            if (accept)
                left_reg <= pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    // line store: read the row above and overwrite it in the same transfer
    assign ram_wr_en   = accept;
    assign ram_addr    = col_reg[rce_pkg::ADDR_W-1:0];
    assign ram_wr_data = pixel;

    assign item_valid = valid_reg;
    assign item       = item_reg;

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !row_end |=> col_reg == $past(col_reg) + rce_pkg::TAG_W'(1))
        else $error("column counter did not advance");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && row_end && last_row |=> col_reg == '0 && row_reg == '0)
        else $error("frame did not wrap at last row end");

endmodule

`default_nettype wire

// ===== sv/rce_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rce_emit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    input  wire rce_pkg::rce_item_t          item,
    input  wire logic [rce_pkg::PIX_W-1:0]   above,
    output logic                             item_done,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output logic      [rce_pkg::PIX_W-1:0]   edge_res,
    output logic      [rce_pkg::TAG_W-1:0]   out_row,
    output logic      [rce_pkg::TAG_W-1:0]   out_col,
    output logic                             last_of_item
);

    logic [rce_pkg::PIX_W-1:0] aleft_reg;
    logic [3:0]                sent_reg;
    logic [3:0]                sent_next;
    logic [3:0]                exists;
    logic [3:0]                pending;
    logic [3:0]                pick;
    logic                      slot_free;
    logic                      fire;
    logic [rce_pkg::PIX_W-1:0] a;
    logic [rce_pkg::PIX_W-1:0] b;
    logic [rce_pkg::PIX_W-1:0] e;
    logic [rce_pkg::PIX_W-1:0] d;
    logic [rce_pkg::TAG_W-1:0] r_sel;
    logic [rce_pkg::TAG_W-1:0] c_sel;
    logic signed [rce_pkg::PIX_W:0] gy;
    logic signed [rce_pkg::PIX_W:0] gx;
    logic [rce_pkg::PIX_W-1:0] gy_c;
    logic [rce_pkg::PIX_W-1:0] gx_c;
    logic                      res_valid_reg;
    logic [rce_pkg::PIX_W-1:0] edge_reg;
    logic [rce_pkg::TAG_W-1:0] row_out_reg;
    logic [rce_pkg::TAG_W-1:0] col_out_reg;
    logic                      last_reg;

    // which of the four results this pixel causes, in emission order
    always_comb
    begin
        exists[0] = (item.row != '0) && (item.col != '0);
        exists[1] = (item.row != '0) && item.row_end;
        exists[2] = item.last_row && (item.col != '0);
        exists[3] = item.last_row && item.row_end;
    end

    assign pending   = item_valid ? (exists & ~sent_reg) : 4'b0000;
    assign slot_free = !res_valid_reg || res_ready;
    assign fire      = (pending != 4'b0000) && slot_free;
    assign item_done = item_valid && ((pending == 4'b0000) || (fire && $onehot(pending)));

    // lowest pending result first
    assign pick = pending & (~pending + 4'b0001);

    // window taps for the picked result
    always_comb
    begin
        a     = item.pixel;
        b     = '0;
        e     = '0;
        d     = '0;
        r_sel = item.row;
        c_sel = item.col;
        case (pick)
            4'b0001:
            begin
                a     = aleft_reg;
                b     = above;
                e     = item.left;
                d     = item.pixel;
                r_sel = item.row - rce_pkg::TAG_W'(1);
                c_sel = item.col - rce_pkg::TAG_W'(1);
            end
            4'b0010:
            begin
                a     = above;
                e     = item.pixel;
                r_sel = item.row - rce_pkg::TAG_W'(1);
            end
            4'b0100:
            begin
                a     = item.left;
                b     = item.pixel;
                c_sel = item.col - rce_pkg::TAG_W'(1);
            end
            default: ;
        endcase
    end

    // two gradients, clamped at zero, larger one wins
    assign gy   = $signed({1'b0, e}) - $signed({1'b0, b});
    assign gx   = $signed({1'b0, d}) - $signed({1'b0, a});
    assign gy_c = gy[rce_pkg::PIX_W] ? '0 : gy[rce_pkg::PIX_W-1:0];
    assign gx_c = gx[rce_pkg::PIX_W] ? '0 : gx[rce_pkg::PIX_W-1:0];

    // track results already sent for the current pixel
    always_comb
    begin
        sent_next = sent_reg;
        if (item_done)
            sent_next = '0;
        else if (fire)
            sent_next = sent_reg | pick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg      <= '0;
            aleft_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg <= sent_next;
            if (item_done)
                aleft_reg <= above;
            if (fire)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            edge_reg    <= (gx_c > gy_c) ? gx_c : gy_c;
            row_out_reg <= r_sel;
            col_out_reg <= c_sel;
            last_reg    <= $onehot(pending);
        end
    end

    assign res_valid    = res_valid_reg;
    assign edge_res     = edge_reg;
    assign out_row      = row_out_reg;
    assign out_col      = col_out_reg;
    assign last_of_item = last_reg;

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        item_done && pending != 4'b0000 |=> res_valid && last_of_item)
        else $error("pixel finished without its last result");

    a_sent_subset: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid |-> (sent_reg & ~exists) == 4'b0000)
        else $error("sent mask holds a result that does not exist");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> !$past(fire) || !$past(res_valid) || $past(res_ready))
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== sv/roberts_cross_edge.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Roberts cross edge detector for a grey raster stream, one pixel per transfer.
// Results for row r-1 leave one pixel behind the input of row r; the row end
// and every pixel of the last row add their own results, tagged with row and
// column, and last_of_item marks the final result caused by a pixel. A pixel
// causes k results (0 to 4), sent by the single result register one per cycle
// unless res_ready stalls it, and holds the window stage until they are sent;
// interior pixels stream at one per cycle unless stalled, row ends and last-row
// pixels cause up to two results and the last row end up to four. A pixel is
// registered in the window stage, then its result in the result register. The
// previous row sits in a 1024 x 8 single-port-style line store whose contents
// are undefined after reset; first-row reads go unused, so no clearing pass is
// needed. Width and height registers reset to 1024, a value of zero acts as one,
// and they should be written only while the block is idle.
module roberts_cross_edge (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [rce_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          pix_valid,
    output logic                               pix_ready,
    input  wire logic [rce_pkg::PIX_W-1:0]     pixel,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic      [rce_pkg::PIX_W-1:0]     edge_res,
    output logic      [rce_pkg::TAG_W-1:0]     out_row,
    output logic      [rce_pkg::TAG_W-1:0]     out_col,
    output logic                               last_of_item
);

    rce_pkg::rce_item_t         item;
    logic                       item_valid;
    logic                       item_done;
    logic                       ram_wr_en;
    logic [rce_pkg::ADDR_W-1:0] ram_addr;
    logic [rce_pkg::PIX_W-1:0]  ram_wr_data;
    logic [rce_pkg::PIX_W-1:0]  above;

    // raster counters, config and window stage
    rce_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pixel       (pixel),
        .item_done   (item_done),
        .item_valid  (item_valid),
        .item        (item),
        .ram_wr_en   (ram_wr_en),
        .ram_addr    (ram_addr),
        .ram_wr_data (ram_wr_data)
    );

    // previous row
    rce_ram #(
        .WIDTH (rce_pkg::PIX_W),
        .DEPTH (rce_pkg::MAX_WIDTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_wr_en),
        .rd_addr (ram_addr),
        .rd_data (above)
    );

    // gradients and result sequencing
    rce_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .above        (above),
        .item_done    (item_done),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .edge_res     (edge_res),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_item (last_of_item)
    );

endmodule

`default_nettype wire
